/* sv/gpp_pkg.sv */
// shared types and codes for the grid path planner
package gpp_pkg;

   // command codes of an input transaction
   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_RUN    = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // configuration register indexes
   localparam logic [2:0] REG_START_X = 3'd0;
   localparam logic [2:0] REG_START_Y = 3'd1;
   localparam logic [2:0] REG_END_X   = 3'd2;
   localparam logic [2:0] REG_END_Y   = 3'd3;
   localparam logic [2:0] REG_PENALTY = 3'd4;

   // neighbour directions in search order
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] cell_index;
      logic       is_wall;
   } req_type;

   typedef struct packed {
      logic [3:0]  cell_x;
      logic [3:0]  cell_y;
      logic [31:0] step_cost;
      logic [8:0]  path_length;
      logic        last_step;
      logic        path_empty;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CLEAR,
      S_SEED,
      S_POP,
      S_CUR_RD,
      S_CUR_WR,
      S_NB_RD,
      S_NB_CHK,
      S_BT_INIT,
      S_BT_CUR,
      S_BN_RD,
      S_BN_CHK,
      S_BT_STEP,
      S_RUN_DONE,
      S_RD_PATH,
      S_RD_COST,
      S_RD_DONE,
      S_EMIT
   } state_type;

endpackage

/* sv/grid_path_planner.sv */
// grid path planner: wavefront cost search over a wall map, backtrack and path read-out
// a run clears the cost store, then pops queued cells and relaxes each neighbour, then
// backtracks from the goal; a path read fetches the next stored step and its cost
// throughput: one transaction at a time; after a run or read, req_stall stays high until the result is registered
// reset: synchronous; control state, path count and read pointer clear, registers load defaults
module grid_path_planner #(
   parameter int MAP_WIDTH  = 16,
   parameter int MAP_HEIGHT = 16,
   parameter int COST_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gpp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gpp_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [19:0]      csr_wdata
);
   import gpp_pkg::*;

   localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
   localparam int CW    = $clog2(CELLS);
   localparam int XW    = $clog2(MAP_WIDTH);
   localparam int YW    = $clog2(MAP_HEIGHT);
   localparam int QW    = XW + YW;
   localparam int MW    = COST_WIDTH + 2;
   localparam int CIW   = CW + 8;
   localparam logic [6:0]            W7        = 7'(MAP_WIDTH);
   localparam logic [6:0]            H7        = 7'(MAP_HEIGHT);
   localparam logic [CW:0]           CELLS_C   = (CW + 1)'(CELLS);
   localparam logic [CW-1:0]         LAST_CELL = CW'(CELLS - 1);
   localparam logic [XW-1:0]         X_LAST    = XW'(MAP_WIDTH - 1);
   localparam logic [YW-1:0]         Y_LAST    = YW'(MAP_HEIGHT - 1);
   localparam logic [COST_WIDTH-1:0] COST_MAX  = {COST_WIDTH{1'b1}};

   // flat cell address from coordinates
   function automatic logic [CW-1:0] cidx(input logic [YW-1:0] y, input logic [XW-1:0] x);
      logic [CW+YW-1:0] yw;
      logic [CW+XW-1:0] xw;
      yw = {{CW{1'b0}}, y};
      xw = {{CW{1'b0}}, x};
      return yw[CW-1:0] * CW'(MAP_WIDTH) + xw[CW-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [3:0]            start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [19:0]           pen_ff;
   logic [CW:0]           count_ff, count_in, rp_ff, rp_in, fill_ff, fill_in;
   logic [CW-1:0]         head_ff, head_in, tail_ff, tail_in, clr_ff, clr_in;
   logic [XW-1:0]         cur_x_ff, cur_x_in, best_x_ff, best_x_in;
   logic [YW-1:0]         cur_y_ff, cur_y_in, best_y_ff, best_y_in;
   logic [COST_WIDTH-1:0] cc_ff, cc_in, best_cost_ff, best_cost_in, goal_cost_ff, goal_cost_in;
   logic [1:0]            d_ff, d_in;
   logic                  found_ff, found_in;
   rsp_type               pend_ff, pend_in, rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // ram ports
   logic          cm_we, wm_we, qm_we, pm_we;
   logic [CW-1:0] cm_wa, cm_ra, wm_wa, wm_ra, qm_wa, qm_ra, pm_wa, pm_ra;
   logic [MW-1:0] cm_wd, cm_rd;
   logic          wm_wd, wm_rd;
   logic [QW-1:0] qm_wd, qm_rd, pm_wd, pm_rd;

   // cost word: queued mark, explored bit, cost
   gpp_ram #(.WIDTH(MW), .DEPTH(CELLS)) u_cost (
      .clock(clock), .wr_en(cm_we), .wr_addr(cm_wa), .wr_data(cm_wd),
      .rd_addr(cm_ra), .rd_data(cm_rd));
   gpp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
      .clock(clock), .wr_en(wm_we), .wr_addr(wm_wa), .wr_data(wm_wd),
      .rd_addr(wm_ra), .rd_data(wm_rd));
   gpp_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
      .clock(clock), .wr_en(qm_we), .wr_addr(qm_wa), .wr_data(qm_wd),
      .rd_addr(qm_ra), .rd_data(qm_rd));
   gpp_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_path (
      .clock(clock), .wr_en(pm_we), .wr_addr(pm_wa), .wr_data(pm_wd),
      .rd_addr(pm_ra), .rd_data(pm_rd));

   logic                  cm_q, cm_e;
   logic [COST_WIDTH-1:0] cm_c;
   assign cm_q = cm_rd[MW-1];
   assign cm_e = cm_rd[MW-2];
   assign cm_c = cm_rd[COST_WIDTH-1:0];

   // start and goal coordinates, range check
   logic [XW+3:0] sx_w, ex_w;
   logic [YW+3:0] sy_w, ey_w;
   logic [XW-1:0] sx, ex;
   logic [YW-1:0] sy, ey;
   logic          grid_ok;
   assign sx_w = {{XW{1'b0}}, start_x_ff};
   assign ex_w = {{XW{1'b0}}, end_x_ff};
   assign sy_w = {{YW{1'b0}}, start_y_ff};
   assign ey_w = {{YW{1'b0}}, end_y_ff};
   assign sx = sx_w[XW-1:0];
   assign ex = ex_w[XW-1:0];
   assign sy = sy_w[YW-1:0];
   assign ey = ey_w[YW-1:0];
   assign grid_ok = ({3'b0, start_x_ff} < W7) && ({3'b0, start_y_ff} < H7)
                 && ({3'b0, end_x_ff} < W7) && ({3'b0, end_y_ff} < H7);

   // neighbour of the current cell in direction d
   logic [XW-1:0] nb_x;
   logic [YW-1:0] nb_y;
   logic          nb_ok;
   always_comb begin
      nb_x  = cur_x_ff;
      nb_y  = cur_y_ff;
      nb_ok = 1'b0;
      case (d_ff)
         DIR_RIGHT: begin
            nb_x  = cur_x_ff + XW'(1);
            nb_ok = cur_x_ff != X_LAST;
         end
         DIR_UP: begin
            nb_y  = cur_y_ff - YW'(1);
            nb_ok = cur_y_ff != '0;
         end
         DIR_LEFT: begin
            nb_x  = cur_x_ff - XW'(1);
            nb_ok = cur_x_ff != '0;
         end
         DIR_DOWN: begin
            nb_y  = cur_y_ff + YW'(1);
            nb_ok = cur_y_ff != Y_LAST;
         end
         default: nb_ok = 1'b0;
      endcase
   end

   logic [CW-1:0] nb_idx;
   assign nb_idx = cidx(nb_y, nb_x);

   // relaxed cost with saturation
   logic [COST_WIDTH:0]   add_c, sum_c;
   logic [COST_WIDTH-1:0] nc;
   logic                  improve;
   assign add_c   = wm_rd ? {{(COST_WIDTH-19){1'b0}}, pen_ff} : (COST_WIDTH + 1)'(1);
   assign sum_c   = {1'b0, cc_ff} + add_c;
   assign nc      = sum_c[COST_WIDTH] ? COST_MAX : sum_c[COST_WIDTH-1:0];
   assign improve = !cm_e || (nc < cm_c);

   // map write address
   logic [CIW-1:0] ci_w;
   logic           ci_ok;
   assign ci_w  = {{CW{1'b0}}, req_data.cell_index};
   assign ci_ok = ci_w < CIW'(CELLS);

   // output widths
   logic [COST_WIDTH+31:0] goal_w, cmc_w;
   logic [CW+9:0]          cnt_w;
   logic [XW+3:0]          cx_w;
   logic [YW+3:0]          cy_w;
   logic [CW:0]            rd_pos;
   assign goal_w = {32'b0, goal_cost_ff};
   assign cmc_w  = {32'b0, cm_c};
   assign cnt_w  = {9'b0, count_ff};
   assign cx_w   = {4'b0, cur_x_ff};
   assign cy_w   = {4'b0, cur_y_ff};
   assign rd_pos = count_ff - rp_ff - (CW + 1)'(1);

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // queue pointer wrap
   logic [CW-1:0] head_nx, tail_nx;
   assign head_nx = (head_ff == LAST_CELL) ? '0 : head_ff + CW'(1);
   assign tail_nx = (tail_ff == LAST_CELL) ? '0 : tail_ff + CW'(1);

   logic bt_better;
   assign bt_better = found_ff && (best_cost_ff < cc_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.cmd)
                  CMD_RUN:  state_in = S_CLEAR;
                  CMD_READ: state_in = (rp_ff < count_ff) ? S_RD_PATH : S_EMIT;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR:    if (clr_ff == LAST_CELL) state_in = S_SEED;
         S_SEED:     state_in = grid_ok ? S_POP : S_RUN_DONE;
         S_POP:      state_in = (fill_ff == '0) ? S_BT_INIT : S_CUR_RD;
         S_CUR_RD:   state_in = S_CUR_WR;
         S_CUR_WR:   state_in = S_NB_RD;
         S_NB_RD: begin
            if (nb_ok) state_in = S_NB_CHK;
            else if (d_ff == DIR_DOWN) state_in = S_POP;
         end
         S_NB_CHK:   state_in = (d_ff == DIR_DOWN) ? S_POP : S_NB_RD;
         S_BT_INIT:  state_in = S_BT_CUR;
         S_BT_CUR:   state_in = (cm_c == '0) ? S_RUN_DONE : S_BN_RD;
         S_BN_RD: begin
            if (nb_ok) state_in = S_BN_CHK;
            else if (d_ff == DIR_DOWN) state_in = S_BT_STEP;
         end
         S_BN_CHK:   state_in = (d_ff == DIR_DOWN) ? S_BT_STEP : S_BN_RD;
         S_BT_STEP: begin
            if (bt_better && (best_cost_ff != '0) && (count_ff + (CW + 1)'(1) < CELLS_C))
               state_in = S_BN_RD;
            else
               state_in = S_RUN_DONE;
         end
         S_RUN_DONE: state_in = S_EMIT;
         S_RD_PATH:  state_in = S_RD_COST;
         S_RD_COST:  state_in = S_RD_DONE;
         S_RD_DONE:  state_in = S_EMIT;
         S_EMIT:     if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and ram control per state
   always_comb begin
      count_in     = count_ff;
      rp_in        = rp_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      clr_in       = clr_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      cc_in        = cc_ff;
      best_cost_in = best_cost_ff;
      goal_cost_in = goal_cost_ff;
      d_in         = d_ff;
      found_in     = found_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cm_we = 1'b0;  cm_wa = '0;  cm_wd = '0;  cm_ra = '0;
      wm_we = 1'b0;  wm_wa = '0;  wm_wd = 1'b0; wm_ra = '0;
      qm_we = 1'b0;  qm_wa = '0;  qm_wd = '0;  qm_ra = '0;
      pm_we = 1'b0;  pm_wa = '0;  pm_wd = '0;  pm_ra = '0;
      case (state_ff)
         // take a transaction
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.cmd)
                  CMD_WRITE: begin
                     wm_we = ci_ok;
                     wm_wa = ci_w[CW-1:0];
                     wm_wd = req_data.is_wall;
                  end
                  CMD_RUN: begin
                     count_in = '0;
                     rp_in    = '0;
                     clr_in   = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     fill_in  = '0;
                  end
                  CMD_READ: begin
                     pend_in             = '0;
                     pend_in.path_length = cnt_w[8:0];
                     pend_in.path_empty  = 1'b1;
                  end
                  default: pend_in = pend_ff;
               endcase
            end
         end
         // clearing pass over the cost store
         S_CLEAR: begin
            cm_we  = 1'b1;
            cm_wa  = clr_ff;
            clr_in = clr_ff + CW'(1);
         end
         // start cell explored at zero and queued
         S_SEED: begin
            goal_cost_in = '0;
            if (grid_ok) begin
               cm_we   = 1'b1;
               cm_wa   = cidx(sy, sx);
               cm_wd   = {2'b11, {COST_WIDTH{1'b0}}};
               qm_we   = 1'b1;
               qm_wa   = tail_ff;
               qm_wd   = {sy, sx};
               tail_in = tail_nx;
               fill_in = (CW + 1)'(1);
            end
         end
         // pop the queue head
         S_POP: begin
            if (fill_ff != '0) begin
               qm_ra   = head_ff;
               head_in = head_nx;
               fill_in = fill_ff - (CW + 1)'(1);
            end
         end
         S_CUR_RD: begin
            cur_x_in = qm_rd[XW-1:0];
            cur_y_in = qm_rd[QW-1:XW];
            cm_ra    = cidx(qm_rd[QW-1:XW], qm_rd[XW-1:0]);
         end
         // drop the queued mark of the popped cell
         S_CUR_WR: begin
            cc_in = cm_c;
            cm_we = 1'b1;
            cm_wa = cidx(cur_y_ff, cur_x_ff);
            cm_wd = {1'b0, cm_e, cm_c};
            d_in  = DIR_RIGHT;
         end
         S_NB_RD: begin
            cm_ra = nb_idx;
            wm_ra = nb_idx;
            if (!nb_ok) d_in = d_ff + 2'd1;
         end
         // relax one neighbour
         S_NB_CHK: begin
            if (improve) begin
               cm_we = 1'b1;
               cm_wa = nb_idx;
               cm_wd = {2'b11, nc};
               if (!cm_q) begin
                  qm_we   = 1'b1;
                  qm_wa   = tail_ff;
                  qm_wd   = {nb_y, nb_x};
                  tail_in = tail_nx;
                  fill_in = fill_ff + (CW + 1)'(1);
               end
            end
            d_in = d_ff + 2'd1;
         end
         // backtrack from the goal
         S_BT_INIT: begin
            cm_ra    = cidx(ey, ex);
            pm_we    = 1'b1;
            pm_wa    = '0;
            pm_wd    = {ey, ex};
            count_in = (CW + 1)'(1);
            cur_x_in = ex;
            cur_y_in = ey;
         end
         S_BT_CUR: begin
            cc_in        = cm_c;
            goal_cost_in = cm_c;
            d_in         = DIR_RIGHT;
            found_in     = 1'b0;
         end
         S_BN_RD: begin
            cm_ra = nb_idx;
            if (!nb_ok) d_in = d_ff + 2'd1;
         end
         // keep the first lowest explored neighbour
         S_BN_CHK: begin
            if (cm_e && (!found_ff || (cm_c < best_cost_ff))) begin
               found_in     = 1'b1;
               best_x_in    = nb_x;
               best_y_in    = nb_y;
               best_cost_in = cm_c;
            end
            d_in = d_ff + 2'd1;
         end
         S_BT_STEP: begin
            if (bt_better) begin
               pm_we    = 1'b1;
               pm_wa    = count_ff[CW-1:0];
               pm_wd    = {best_y_ff, best_x_ff};
               count_in = count_ff + (CW + 1)'(1);
               cur_x_in = best_x_ff;
               cur_y_in = best_y_ff;
               cc_in    = best_cost_ff;
            end
            d_in     = DIR_RIGHT;
            found_in = 1'b0;
         end
         S_RUN_DONE: begin
            pend_in.cell_x      = end_x_ff;
            pend_in.cell_y      = end_y_ff;
            pend_in.step_cost   = goal_w[31:0];
            pend_in.path_length = cnt_w[8:0];
            pend_in.last_step   = 1'b0;
            pend_in.path_empty  = count_ff == '0;
         end
         // path is stored goal first, so read from the far end
         S_RD_PATH: pm_ra = rd_pos[CW-1:0];
         S_RD_COST: begin
            cur_x_in = pm_rd[XW-1:0];
            cur_y_in = pm_rd[QW-1:XW];
            cm_ra    = cidx(pm_rd[QW-1:XW], pm_rd[XW-1:0]);
         end
         S_RD_DONE: begin
            pend_in.cell_x      = cx_w[3:0];
            pend_in.cell_y      = cy_w[3:0];
            pend_in.step_cost   = cmc_w[31:0];
            pend_in.path_length = cnt_w[8:0];
            pend_in.last_step   = (rp_ff + (CW + 1)'(1)) == count_ff;
            pend_in.path_empty  = 1'b0;
            rp_in               = rp_ff + (CW + 1)'(1);
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
            end
         end
         default: pend_in = pend_ff;
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_x_ff   <= 4'd1;
         start_y_ff   <= 4'd1;
         end_x_ff     <= 4'd14;
         end_y_ff     <= 4'd14;
         pen_ff       <= 20'd999999;
         count_ff     <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         clr_ff       <= '0;
         d_ff         <= DIR_RIGHT;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         clr_ff       <= clr_in;
         d_ff         <= d_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_START_X: start_x_ff <= csr_wdata[3:0];
               REG_START_Y: start_y_ff <= csr_wdata[3:0];
               REG_END_X:   end_x_ff   <= csr_wdata[3:0];
               REG_END_Y:   end_y_ff   <= csr_wdata[3:0];
               REG_PENALTY: pen_ff     <= csr_wdata;
               default:     pen_ff     <= pen_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      best_x_ff    <= best_x_in;
      best_y_ff    <= best_y_in;
      cc_ff        <= cc_in;
      best_cost_ff <= best_cost_in;
      goal_cost_ff <= goal_cost_in;
      pend_ff      <= pend_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // each cell sits in the queue at most once
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CELLS_C) else $error("queue fill beyond cell count");
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= count_ff) else $error("read pointer past path count");
   a_seed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEED) && grid_ok |=> (fill_ff == (CW + 1)'(1)) && (state_ff == S_POP))
      else $error("seed did not queue the start cell");
`endif
endmodule

/* sv/gpp_ram.sv */
// generic single write, single read ram with registered read data
module gpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* tb/testbench.sv */
// testbench for the grid path planner: directed and random command streams checked
// against an in-bench cost search and backtrack predictor
`timescale 1ns / 1ps

module testbench;
   import gpp_pkg::*;

   localparam int CELL_COUNT = 256;
   localparam longint unsigned COST_CEIL = 64'hFFFF_FFFF;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [19:0] csr_wdata;

   grid_path_planner DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [3:0]  pl_start_x, pl_start_y, pl_end_x, pl_end_y;
   logic [19:0] pl_penalty;
   bit               map_wall [CELL_COUNT];
   longint unsigned  cell_cost [CELL_COUNT];
   bit               cell_seen [CELL_COUNT];
   bit               cell_queued [CELL_COUNT];
   int               route [CELL_COUNT];
   int               route_len;
   int               read_ptr;

   req_type pending_reqs [$];
   rsp_type expected_steps [$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int runs_done = 0;
   int reads_done = 0;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // wavefront relaxation then backtrack from the goal
   task automatic plan_route();
      int frontier [$];
      int c, cx, cy, nx, ny, nb, n, cur, best, d;
      longint unsigned nc, cc, best_cost;
      bit found;
      int dx [4] = '{1, 0, -1, 0};
      int dy [4] = '{0, -1, 0, 1};
      for (int i = 0; i < CELL_COUNT; i++) begin
         cell_cost[i] = 0;
         cell_seen[i] = 0;
         cell_queued[i] = 0;
      end
      route_len = 0;
      read_ptr = 0;
      c = pl_start_y * 16 + pl_start_x;
      cell_seen[c] = 1;
      cell_queued[c] = 1;
      frontier = {frontier, c};
      while (frontier.size() > 0) begin
         c = frontier.pop_front();
         cell_queued[c] = 0;
         cx = c % 16;
         cy = c / 16;
         for (d = 0; d < 4; d++) begin
            nx = cx + dx[d];
            ny = cy + dy[d];
            if (nx < 0 || ny < 0 || nx >= 16 || ny >= 16) continue;
            nb = ny * 16 + nx;
            nc = cell_cost[c] + (map_wall[nb] ? longint'(pl_penalty) : 1);
            if (nc > COST_CEIL) nc = COST_CEIL;
            if (!cell_seen[nb] || nc < cell_cost[nb]) begin
               cell_seen[nb] = 1;
               cell_cost[nb] = nc;
               if (!cell_queued[nb]) begin
                  cell_queued[nb] = 1;
                  frontier = {frontier, nb};
               end
            end
         end
      end
      // backtrack, first lowest neighbour in right, up, left, down order
      cur = pl_end_y * 16 + pl_end_x;
      n = 0;
      route[n++] = cur;
      cc = cell_cost[cur];
      while (cc > 0 && n < CELL_COUNT) begin
         cx = cur % 16;
         cy = cur / 16;
         found = 0;
         best = 0;
         best_cost = 0;
         for (d = 0; d < 4; d++) begin
            nx = cx + dx[d];
            ny = cy + dy[d];
            if (nx < 0 || ny < 0 || nx >= 16 || ny >= 16) continue;
            nb = ny * 16 + nx;
            if (!cell_seen[nb]) continue;
            if (!found || cell_cost[nb] < best_cost) begin
               found = 1;
               best = nb;
               best_cost = cell_cost[nb];
            end
         end
         if (!found || best_cost >= cc) break;
         cur = best;
         cc = best_cost;
         route[n++] = cur;
      end
      for (int i = 0; i < n / 2; i++) begin
         c = route[i];
         route[i] = route[n - 1 - i];
         route[n - 1 - i] = c;
      end
      route_len = n;
   endtask

   // expected result of one accepted transaction
   task automatic predict_step(input req_type r);
      rsp_type e;
      int c;
      e = '0;
      case (r.cmd)
         CMD_WRITE: map_wall[r.cell_index] = r.is_wall;
         CMD_RUN: begin
            plan_route();
            e.cell_x = pl_end_x;
            e.cell_y = pl_end_y;
            e.step_cost = route_len > 0 ? cell_cost[route[route_len - 1]][31:0] : 32'd0;
            e.path_length = route_len[8:0];
            e.path_empty = (route_len == 0);
            expected_steps = {expected_steps, e};
            runs_done++;
         end
         CMD_READ: begin
            e.path_length = route_len[8:0];
            if (read_ptr < route_len) begin
               c = route[read_ptr];
               e.cell_x = 4'(c % 16);
               e.cell_y = 4'(c / 16);
               e.step_cost = cell_cost[c][31:0];
               e.last_step = (read_ptr + 1 == route_len);
               read_ptr++;
            end else begin
               e.path_empty = 1'b1;
            end
            expected_steps = {expected_steps, e};
            reads_done++;
         end
         default: ;
      endcase
   endtask

   // driver: presents pending transactions with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) predict_step(req_data);
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: receiver stalls and field checks
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_steps.size() == 0) begin
               $error("result with nothing expected: %p", rsp_data);
               error_count++;
            end else begin
               e = expected_steps.pop_front();
               if (rsp_data.cell_x !== e.cell_x) begin
                  $error("cell_x expected %0d got %0d", e.cell_x, rsp_data.cell_x);
                  error_count++;
               end
               if (rsp_data.cell_y !== e.cell_y) begin
                  $error("cell_y expected %0d got %0d", e.cell_y, rsp_data.cell_y);
                  error_count++;
               end
               if (rsp_data.step_cost !== e.step_cost) begin
                  $error("step_cost expected %0d got %0d", e.step_cost, rsp_data.step_cost);
                  error_count++;
               end
               if (rsp_data.path_length !== e.path_length) begin
                  $error("path_length expected %0d got %0d", e.path_length,
                         rsp_data.path_length);
                  error_count++;
               end
               if (rsp_data.last_step !== e.last_step) begin
                  $error("last_step expected %0d got %0d", e.last_step, rsp_data.last_step);
                  error_count++;
               end
               if (rsp_data.path_empty !== e.path_empty) begin
                  $error("path_empty expected %0d got %0d", e.path_empty, rsp_data.path_empty);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // wait until every transaction is in and every result is out
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_steps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_START_X: pl_start_x = val[3:0];
         REG_START_Y: pl_start_y = val[3:0];
         REG_END_X:   pl_end_x = val[3:0];
         REG_END_Y:   pl_end_y = val[3:0];
         REG_PENALTY: pl_penalty = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_route(input int sx, input int sy, input int ex, input int ey,
                            input int pen);
      drain();
      write_reg(REG_START_X, 20'(sx));
      write_reg(REG_START_Y, 20'(sy));
      write_reg(REG_END_X, 20'(ex));
      write_reg(REG_END_Y, 20'(ey));
      write_reg(REG_PENALTY, 20'(pen));
   endtask

   task automatic push_req(input logic [1:0] cmd, input int idx, input bit wall);
      req_type r;
      r.cmd = cmd;
      r.cell_index = 8'(idx);
      r.is_wall = wall;
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic push_reads(input int count);
      for (int i = 0; i < count; i++) push_req(CMD_READ, $urandom_range(255), $urandom_range(1));
   endtask

   // stimulus
   initial begin
      int pen;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      pl_start_x = 4'd1;
      pl_start_y = 4'd1;
      pl_end_x = 4'd14;
      pl_end_y = 4'd14;
      pl_penalty = 20'd999999;
      route_len = 0;
      read_ptr = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 50;

      // read before any run, unused command, then the whole map
      push_req(CMD_READ, 0, 0);
      push_req(CMD_UNUSED, 8'hFF, 1);
      for (int i = 0; i < CELL_COUNT; i++) push_req(CMD_WRITE, i, $urandom_range(3) == 0);
      // default registers, reads run past the end of the path
      push_req(CMD_RUN, 0, 0);
      push_reads(32);
      // start equal to goal
      set_route(0, 0, 0, 0, 1);
      push_req(CMD_RUN, 0, 0);
      push_reads(2);
      // corner to corner with the largest and smallest penalty
      set_route(0, 0, 15, 15, 20'hFFFFF);
      push_req(CMD_RUN, 0, 0);
      push_reads(32);
      set_route(15, 15, 0, 0, 1);
      push_req(CMD_RUN, 0, 0);
      push_reads(32);

      // random phases: map edits, a run, then a burst of reads
      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 16;
         end else if (ph == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(3))
            0: pen = 1;
            1: pen = 20'hFFFFF;
            default: pen = $urandom_range(20'hFFFFF, 1);
         endcase
         set_route($urandom_range(15), $urandom_range(15), $urandom_range(15),
                   $urandom_range(15), pen);
         for (int i = 0; i < 6; i++)
            push_req(CMD_WRITE, $urandom_range(255), $urandom_range(2) == 0);
         if ($urandom_range(3) == 0)
            push_req(CMD_UNUSED, $urandom_range(255), $urandom_range(1));
         push_req(CMD_RUN, $urandom_range(255), $urandom_range(1));
         push_reads($urandom_range(32, 1));
      end

      drain();
      repeat (50) @(posedge clock);
      if (expected_steps.size() > 0) error_count++;
      $display("covered %0d search runs and %0d path reads over several start, goal and",
               runs_done, reads_done);
      $display("penalty settings, with sender and receiver gaps in turn");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // run limit
   initial begin
      #400_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
